// ===== design/pbas_pkg.sv =====
// Shared types and constants of the packed bit array store.
`default_nettype none

package pbas_pkg;

  localparam int MaxEntries = 4096;
  localparam int WordBits   = 64;
  localparam int MaxWidth   = 32;
  localparam int StoreWords = (MaxEntries * MaxWidth + WordBits - 1) / WordBits;
  localparam int AddrW      = $clog2(StoreWords);
  localparam int ShiftW     = $clog2(WordBits);
  localparam int FirstW     = $clog2(MaxEntries * MaxWidth);
  localparam int IdxW       = 12;
  localparam int WidthW     = 6;
  localparam int CountW     = 13;
  localparam int ValW       = 32;
  localparam int CfgW       = 13;

  localparam logic [WidthW-1:0] BpeReset   = WidthW'(1);
  localparam logic [CountW-1:0] CountReset = CountW'(MaxEntries);

  typedef enum logic {
    FUNC_READ  = 1'b0,
    FUNC_WRITE = 1'b1
  } func_e;

  typedef enum logic {
    CFG_BITS_PER_ENTRY = 1'b0,
    CFG_ENTRY_COUNT    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    func_e            func;
    logic [IdxW-1:0]  index;
    logic [ValW-1:0]  value;
  } item_t;

  typedef struct packed {
    logic [ValW-1:0] read_value;
    logic            index_error;
  } result_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_GEOM,
    ST_RD_LO,
    ST_RD_HI,
    ST_WAIT,
    ST_WR_LO,
    ST_WR_HI,
    ST_DONE
  } state_e;

  // Sequencer to datapath
  typedef struct packed {
    logic             latch;
    logic             geom;
    logic             sel_hi;
    logic             cap_lo;
    logic             cap_hi;
    logic             wr;
    logic             clear;
    logic             finish;
    logic [AddrW-1:0] clr_addr;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic err;
    logic straddle;
    logic is_write;
  } stat_t;

endpackage

`default_nettype wire

// ===== design/packed_bit_array_store_core.sv =====
// Top level of the packed bit array store: config registers, sequencer, datapath, word RAM.
`default_nettype none

// From accepted start to done_o strobe: geometry, low word read (high word too if the entry
//   straddles two words), capture, merged word write-back for a write, then finish; an
//   index error skips to finish. The next start may be taken in the strobe cycle.
// Single-port word RAM: one read or write per cycle. Reset: config returns to width 1,
//   count 4096; then a sweep zeroes all 2048 words, busy high. done_o has no back-pressure.
module packed_bit_array_store_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire pbas_pkg::item_t                 item_i,
  output pbas_pkg::result_t                    result_o,
  output logic                                 done_o,
  input  wire logic                            cfg_we_i,
  input  wire pbas_pkg::cfg_idx_e              cfg_idx_i,
  input  wire logic [pbas_pkg::CfgW-1:0]       cfg_wdata_i
);

  // Configuration registers, writable at any time; count is sampled at accept, width at geometry
  logic [pbas_pkg::WidthW-1:0] bpe_q;
  logic [pbas_pkg::CountW-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpe_q   <= pbas_pkg::BpeReset;
      count_q <= pbas_pkg::CountReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pbas_pkg::CFG_BITS_PER_ENTRY: bpe_q   <= cfg_wdata_i[pbas_pkg::WidthW-1:0];
        pbas_pkg::CFG_ENTRY_COUNT:    count_q <= cfg_wdata_i[pbas_pkg::CountW-1:0];
        default: begin
          bpe_q <= bpe_q;
        end
      endcase
    end
  end

  pbas_pkg::ctrl_t                  ctrl;
  pbas_pkg::stat_t                  stat;
  logic                             ram_we;
  logic [pbas_pkg::AddrW-1:0]       ram_addr;
  logic [pbas_pkg::WordBits-1:0]    ram_wdata, ram_rdata;

  // Sequencer: clear sweep, then per item geometry, word reads, merge writes
  pbas_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .busy_o  (busy)
  );

  // Datapath: index * width -> word address and bit offset, extract, merge
  pbas_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .bpe_i       (bpe_q),
    .count_i     (count_q),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata),
    .result_o    (result_o),
    .done_o      (done_o)
  );

  // Word store: 64-bit words, entries packed from bit 0 of word 0
  pbas_ram #(
    .Width (pbas_pkg::WordBits),
    .Depth (pbas_pkg::StoreWords)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // A result shows up only once the sequencer is back in idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("done while busy");

  // Strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");

  // An accepted item keeps the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("not busy after accept");

  // An out-of-range index returns zero
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.index_error) |-> (result_o.read_value == '0))
    else $error("nonzero value on index error");

  // Erroring items never touch the store
  a_err_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && !ctrl.clear) |-> !stat.err) else $error("write on index error");

endmodule

`default_nettype wire

// ===== design/pbas_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none

module pbas_ram #(
  parameter int Width = 64,
  parameter int Depth = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/pbas_ctrl.sv =====
// Sequencer: clearing sweep and per-item read-modify-write steps.
`default_nettype none

module pbas_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire pbas_pkg::stat_t stat_i,
  output pbas_pkg::ctrl_t     ctrl_o,
  output logic                busy_o
);

  pbas_pkg::state_e                state_q, state_d;
  logic [pbas_pkg::AddrW-1:0]      clr_q, clr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pbas_pkg::ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    clr_d           = clr_q;
    ctrl_o          = '0;
    ctrl_o.clr_addr = clr_q;
    busy_o          = 1'b1;
    case (state_q)
      pbas_pkg::ST_CLEAR: begin
        ctrl_o.clear = 1'b1;
        clr_d        = clr_q + 1'b1;
        if (clr_q == pbas_pkg::AddrW'(pbas_pkg::StoreWords - 1)) begin
          state_d = pbas_pkg::ST_IDLE;
        end
      end
      pbas_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          ctrl_o.latch = 1'b1;
          state_d      = pbas_pkg::ST_GEOM;
        end
      end
      pbas_pkg::ST_GEOM: begin
        ctrl_o.geom = 1'b1;
        state_d     = stat_i.err ? pbas_pkg::ST_DONE : pbas_pkg::ST_RD_LO;
      end
      pbas_pkg::ST_RD_LO: begin
        state_d = stat_i.straddle ? pbas_pkg::ST_RD_HI : pbas_pkg::ST_WAIT;
      end
      pbas_pkg::ST_RD_HI: begin
        ctrl_o.sel_hi = 1'b1;
        ctrl_o.cap_lo = 1'b1;
        state_d       = pbas_pkg::ST_WAIT;
      end
      pbas_pkg::ST_WAIT: begin
        ctrl_o.cap_hi = stat_i.straddle;
        ctrl_o.cap_lo = !stat_i.straddle;
        state_d       = stat_i.is_write ? pbas_pkg::ST_WR_LO : pbas_pkg::ST_DONE;
      end
      pbas_pkg::ST_WR_LO: begin
        ctrl_o.wr = 1'b1;
        state_d   = stat_i.straddle ? pbas_pkg::ST_WR_HI : pbas_pkg::ST_DONE;
      end
      pbas_pkg::ST_WR_HI: begin
        ctrl_o.wr     = 1'b1;
        ctrl_o.sel_hi = 1'b1;
        state_d       = pbas_pkg::ST_DONE;
      end
      pbas_pkg::ST_DONE: begin
        ctrl_o.finish = 1'b1;
        state_d       = pbas_pkg::ST_IDLE;
      end
      default: begin
        state_d = pbas_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/pbas_dpath.sv =====
// Datapath: entry geometry, word capture, extract and merge, result register.
`default_nettype none

module pbas_dpath (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire pbas_pkg::item_t                    item_i,
  input  wire logic [pbas_pkg::WidthW-1:0]        bpe_i,
  input  wire logic [pbas_pkg::CountW-1:0]        count_i,
  input  wire pbas_pkg::ctrl_t                    ctrl_i,
  output pbas_pkg::stat_t                         stat_o,
  output logic                                    ram_we_o,
  output logic [pbas_pkg::AddrW-1:0]              ram_addr_o,
  output logic [pbas_pkg::WordBits-1:0]           ram_wdata_o,
  input  wire logic [pbas_pkg::WordBits-1:0]      ram_rdata_i,
  output pbas_pkg::result_t                       result_o,
  output logic                                    done_o
);

  localparam int WB = pbas_pkg::WordBits;

  pbas_pkg::item_t                    op_q;
  logic                               err_q;
  logic [pbas_pkg::WidthW-1:0]        w_q;
  logic [pbas_pkg::AddrW-1:0]         lo_word_q;
  logic [pbas_pkg::ShiftW-1:0]        shift_q;
  logic                               straddle_q;
  logic [WB-1:0]                      lo_q, hi_q;
  pbas_pkg::result_t                  res_q;
  logic                               done_q;

  logic [pbas_pkg::WidthW-1:0]              w_eff;
  logic [pbas_pkg::IdxW+pbas_pkg::WidthW-1:0] prod;
  logic [pbas_pkg::FirstW-1:0]              first;
  logic [pbas_pkg::ShiftW:0]                end_bit;
  logic [WB-1:0]                            mask;
  logic [2*WB-1:0]                          pair, ext, m2, v2, merged;
  logic [pbas_pkg::ValW-1:0]                rd_val, v_masked;

  // Width zero acts as one, above the maximum as the maximum
  always_comb begin
    if (bpe_i == '0) begin
      w_eff = pbas_pkg::WidthW'(1);
    end else if (bpe_i > pbas_pkg::WidthW'(pbas_pkg::MaxWidth)) begin
      w_eff = pbas_pkg::WidthW'(pbas_pkg::MaxWidth);
    end else begin
      w_eff = bpe_i;
    end
  end

  assign prod    = {{pbas_pkg::WidthW{1'b0}}, op_q.index} *
                   {{pbas_pkg::IdxW{1'b0}}, w_eff};
  assign first   = prod[pbas_pkg::FirstW-1:0];
  assign end_bit = {1'b0, first[pbas_pkg::ShiftW-1:0]} + {1'b0, w_eff};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      op_q  <= item_i;
      err_q <= {1'b0, item_i.index} >= count_i;
    end
    if (ctrl_i.geom) begin
      w_q        <= w_eff;
      lo_word_q  <= first[pbas_pkg::FirstW-1:pbas_pkg::ShiftW];
      shift_q    <= first[pbas_pkg::ShiftW-1:0];
      straddle_q <= end_bit > (pbas_pkg::ShiftW+1)'(WB);
    end
    if (ctrl_i.cap_lo) begin
      lo_q <= ram_rdata_i;
    end
    if (ctrl_i.cap_hi) begin
      hi_q <= ram_rdata_i;
    end
    if (ctrl_i.finish) begin
      res_q.read_value  <= (err_q || op_q.func == pbas_pkg::FUNC_WRITE) ? '0 : rd_val;
      res_q.index_error <= err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctrl_i.finish;
    end
  end

  // Two adjacent words viewed as one 128-bit span; the upper word only
  // matters when the entry straddles
  assign mask     = ({{(WB-1){1'b0}}, 1'b1} << w_q) - {{(WB-1){1'b0}}, 1'b1};
  assign pair     = {hi_q, lo_q};
  assign ext      = pair >> shift_q;
  assign rd_val   = ext[pbas_pkg::ValW-1:0] & mask[pbas_pkg::ValW-1:0];
  assign v_masked = op_q.value & mask[pbas_pkg::ValW-1:0];
  assign m2       = {{WB{1'b0}}, mask} << shift_q;
  assign v2       = {{(2*WB-pbas_pkg::ValW){1'b0}}, v_masked} << shift_q;
  assign merged   = (pair & ~m2) | v2;

  assign ram_we_o   = ctrl_i.wr || ctrl_i.clear;
  assign ram_addr_o = ctrl_i.clear  ? ctrl_i.clr_addr :
                      ctrl_i.sel_hi ? lo_word_q + 1'b1 : lo_word_q;
  assign ram_wdata_o = ctrl_i.clear  ? '0 :
                       ctrl_i.sel_hi ? merged[2*WB-1:WB] : merged[WB-1:0];

  assign stat_o.err      = err_q;
  assign stat_o.straddle = straddle_q;
  assign stat_o.is_write = op_q.func == pbas_pkg::FUNC_WRITE;

  assign result_o = res_q;
  assign done_o   = done_q;

endmodule

`default_nettype wire
